[src/upd_pkg.sv]
// ----------------------------------------------------------------------------
// upd_pkg: shared types for the URL percent decoder
// Word formats, status codes, escape phases and the hex digit decoder.
// ----------------------------------------------------------------------------
package upd_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned LenW  = 13;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_MALFORMED = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_PCT  = 2'd1,
    PH_HIGH = 2'd2
  } phase_e;

  typedef struct packed {
    logic [ByteW-1:0] in_byte;
    logic             last;
  } in_word_t;

  typedef struct packed {
    logic [ByteW-1:0] out_byte;
    logic             byte_valid;
    logic             done_res;
    status_e          status;
    logic [LenW-1:0]  decoded_length;
  } out_word_t;

  // Per-string state other than the output count.
  typedef struct packed {
    phase_e     phase;
    logic [3:0] high_nibble;
    status_e    err;
  } str_state_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  localparam logic [ByteW-1:0] CharPct = 8'h25;

  function automatic hex_t hex_decode(input logic [ByteW-1:0] c);
    hex_t r;
    r.ok  = 1'b0;
    r.val = 4'd0;
    priority if (c >= 8'h30 && c <= 8'h39) begin
      r.ok  = 1'b1;
      r.val = 4'(c - 8'h30);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r.ok  = 1'b1;
      r.val = 4'(c - 8'h41 + 8'd10);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r.ok  = 1'b1;
      r.val = 4'(c - 8'h61 + 8'd10);
    end else begin
      r.ok  = 1'b0;
    end
    return r;
  endfunction

endpackage

[src/url_percent_decoder.sv]
// ----------------------------------------------------------------------------
// url_percent_decoder: streaming URL percent decoder
// Decodes %XX escapes byte by byte and reports per-string status and length.
// ----------------------------------------------------------------------------
// One source byte enters per word on the input channel, with last marking the
// final byte of a string, and every input word yields exactly one result word.
// A '%' and two hex digits (either case) become one byte; any other byte
// passes through. The result for the last byte carries done_res, the status
// (ok, overflow or malformed escape) and, when ok, the decoded length; the
// string state then clears for the next string. The block takes one word per
// clock unless the result register is held by a stall on the output: the
// decode step is a single pass of small logic between the string state
// registers and the result register, so a word's result is registered and
// is presented in the cycle after the word is accepted. The capacity register
// cap_q is clipped to MAX_BUFFER; write it only while no string is in flight.
module url_percent_decoder #(
  parameter int unsigned MAX_BUFFER = 4096
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  upd_pkg::in_word_t          in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output upd_pkg::out_word_t         out_data_o,
  input  logic                       cfg_we_i,
  input  logic [upd_pkg::LenW-1:0]   cfg_data_i
);

  // Largest capacity the count can reach: the register is 13 bits wide.
  localparam int unsigned RegMax = (1 << upd_pkg::LenW) - 1;
  localparam int unsigned CapMax = (MAX_BUFFER < RegMax) ? MAX_BUFFER : RegMax;
  localparam int unsigned CntW   = $clog2(CapMax + 1);
  localparam int unsigned CapRst = (4096 < CapMax) ? 4096 : CapMax;
  localparam int unsigned CmpW   = 17;

  logic                in_accept;
  logic                out_accept;

  // Effective capacity, clipped at write time.
  logic [CntW-1:0]     cap_q, cap_d;

  upd_pkg::str_state_t state_q, state_d;
  logic [CntW-1:0]     count_q, count_d;

  logic                out_valid_q, out_valid_d;
  upd_pkg::out_word_t  out_q, out_d;

  // Hold the input whenever the pending result cannot leave this cycle.
  assign in_stall_o  = out_valid_q & out_stall_i;
  assign in_accept   = in_valid_i & ~in_stall_o;
  assign out_accept  = out_valid_q & ~out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    if (CmpW'(cfg_data_i) < CmpW'(CapMax)) begin
      cap_d = CntW'(cfg_data_i);
    end else begin
      cap_d = CntW'(CapMax);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CntW'(CapRst);
    end else if (cfg_we_i) begin
      cap_q <= cap_d;
    end
  end

  upd_step #(
    .CntW (CntW)
  ) u_step (
    .in_i    (in_data_i),
    .state_i (state_q),
    .count_i (count_q),
    .cap_i   (cap_q),
    .state_o (state_d),
    .count_o (count_d),
    .out_o   (out_d)
  );

  // Advance the string state on every accepted word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.phase       <= upd_pkg::PH_IDLE;
      state_q.high_nibble <= 4'd0;
      state_q.err         <= upd_pkg::ST_OK;
      count_q             <= '0;
    end else if (in_accept) begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  // Result register: fill on accept, drain when the sink takes the word.
  always_comb begin
    out_valid_d = out_valid_q;
    if (in_accept) begin
      out_valid_d = 1'b1;
    end else if (out_accept) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      out_q <= out_d;
    end
  end

`ifndef SYNTHESIS
  a_count_in_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= cap_q)
    else $error("output count beyond capacity");

  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && in_data_i.last |=> count_q == '0 && state_q.err == upd_pkg::ST_OK
      && state_q.phase == upd_pkg::PH_IDLE)
    else $error("string state not cleared after last byte");

  a_byte_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.byte_valid |-> out_q.status == upd_pkg::ST_OK)
    else $error("decoded byte with error status");

  a_idle_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_q.done_res |-> out_q.status == upd_pkg::ST_OK
      && out_q.decoded_length == '0)
    else $error("status or length set before end of string");

  a_error_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && !in_data_i.last && state_q.err != upd_pkg::ST_OK
      |=> $stable(state_q.err) && $stable(count_q))
    else $error("error state changed within string");
`endif

endmodule

[src/upd_step.sv]
// ----------------------------------------------------------------------------
// upd_step: decode step for one source word
// Next string state, next output count and the result word.
// ----------------------------------------------------------------------------
module upd_step #(
  parameter int unsigned CntW = 13
) (
  input  upd_pkg::in_word_t   in_i,
  input  upd_pkg::str_state_t state_i,
  input  logic [CntW-1:0]     count_i,
  input  logic [CntW-1:0]     cap_i,
  output upd_pkg::str_state_t state_o,
  output logic [CntW-1:0]     count_o,
  output upd_pkg::out_word_t  out_o
);

  upd_pkg::hex_t       hex;
  upd_pkg::str_state_t st;
  logic [CntW-1:0]     cnt;

  assign hex = upd_pkg::hex_decode(in_i.in_byte);

  always_comb begin
    st               = state_i;
    cnt              = count_i;
    out_o            = '0;
    out_o.done_res   = in_i.last;
    out_o.status     = upd_pkg::ST_OK;

    if (state_i.err == upd_pkg::ST_OK) begin
      unique case (state_i.phase)
        upd_pkg::PH_PCT: begin
          if (!hex.ok || in_i.last) begin
            st.err = upd_pkg::ST_MALFORMED;
          end else begin
            st.high_nibble = hex.val;
            st.phase       = upd_pkg::PH_HIGH;
          end
        end
        upd_pkg::PH_HIGH: begin
          if (!hex.ok) begin
            st.err = upd_pkg::ST_MALFORMED;
          end else begin
            out_o.out_byte   = {state_i.high_nibble, hex.val};
            out_o.byte_valid = 1'b1;
            cnt              = count_i + CntW'(1);
            st.phase         = upd_pkg::PH_IDLE;
          end
        end
        default: begin
          st.phase = upd_pkg::PH_IDLE;
          // Full buffer wins over the escape check.
          if (count_i >= cap_i) begin
            st.err = upd_pkg::ST_OVERFLOW;
          end else if (in_i.in_byte == upd_pkg::CharPct) begin
            if (in_i.last) begin
              st.err = upd_pkg::ST_MALFORMED;
            end else begin
              st.phase = upd_pkg::PH_PCT;
            end
          end else begin
            out_o.out_byte   = in_i.in_byte;
            out_o.byte_valid = 1'b1;
            cnt              = count_i + CntW'(1);
          end
        end
      endcase
    end

    if (in_i.last) begin
      out_o.status = st.err;
      if (st.err == upd_pkg::ST_OK) begin
        out_o.decoded_length = upd_pkg::LenW'(cnt);
      end
      st.phase       = upd_pkg::PH_IDLE;
      st.high_nibble = 4'd0;
      st.err         = upd_pkg::ST_OK;
      cnt            = '0;
    end

    state_o = st;
    count_o = cnt;
  end

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the URL percent decoder
// Drives strings of raw bytes through the input channel with random gaps,
// stalls the result channel at random, and checks every result word against
// a cycle-free prediction of the decoder kept inside a small scoreboard.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned MAX_BUFFER    = 4096;
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned HoldOffLen    = 300;

  // Scoreboard: tracks the decoder's string state and capacity, turns every
  // accepted input word into the result word the block must produce, and
  // compares arriving results against the oldest one still waiting.
  class decode_checker;
    upd_pkg::out_word_t       expected_words[$];
    int unsigned              mismatches;
    logic [upd_pkg::LenW-1:0] capacity_reg;
    upd_pkg::phase_e          phase;
    logic [3:0]               hi_nib;
    logic [upd_pkg::LenW-1:0] count;
    upd_pkg::status_e         err;

    function new();
      mismatches   = 0;
      capacity_reg = upd_pkg::LenW'(MAX_BUFFER);
      clear_string();
    endfunction

    static function bit hex_value(input logic [7:0] c, output logic [3:0] v);
      v = 4'd0;
      if (c >= "0" && c <= "9") v = 4'(c - "0");
      else if (c >= "A" && c <= "F") v = 4'(c - "A" + 8'd10);
      else if (c >= "a" && c <= "f") v = 4'(c - "a" + 8'd10);
      else return 1'b0;
      return 1'b1;
    endfunction

    function void clear_string();
      phase  = upd_pkg::PH_IDLE;
      hi_nib = 4'd0;
      count  = '0;
      err    = upd_pkg::ST_OK;
    endfunction

    function void set_capacity(input logic [upd_pkg::LenW-1:0] v);
      capacity_reg = v;
    endfunction

    function upd_pkg::out_word_t decode_byte(input upd_pkg::in_word_t w);
      upd_pkg::out_word_t       r;
      logic [upd_pkg::LenW-1:0] cap;
      logic [3:0]               d;
      bit                       is_hex;
      r      = '0;
      cap    = (capacity_reg > upd_pkg::LenW'(MAX_BUFFER)) ?
               upd_pkg::LenW'(MAX_BUFFER) : capacity_reg;
      is_hex = hex_value(w.in_byte, d);
      if (err == upd_pkg::ST_OK) begin
        case (phase)
          upd_pkg::PH_PCT: begin
            // A string may not end inside an escape.
            if (!is_hex || w.last) begin
              err = upd_pkg::ST_MALFORMED;
            end else begin
              hi_nib = d;
              phase  = upd_pkg::PH_HIGH;
            end
          end
          upd_pkg::PH_HIGH: begin
            if (!is_hex) begin
              err = upd_pkg::ST_MALFORMED;
            end else begin
              r.out_byte   = {hi_nib, d};
              r.byte_valid = 1'b1;
              count++;
              phase = upd_pkg::PH_IDLE;
            end
          end
          default: begin
            phase = upd_pkg::PH_IDLE;
            // Capacity is checked before the byte is looked at.
            if (count >= cap) begin
              err = upd_pkg::ST_OVERFLOW;
            end else if (w.in_byte == upd_pkg::CharPct) begin
              if (w.last) err = upd_pkg::ST_MALFORMED;
              else phase = upd_pkg::PH_PCT;
            end else begin
              r.out_byte   = w.in_byte;
              r.byte_valid = 1'b1;
              count++;
            end
          end
        endcase
      end
      if (w.last) begin
        r.done_res       = 1'b1;
        r.status         = err;
        r.decoded_length = (err == upd_pkg::ST_OK) ? count : '0;
        clear_string();
      end
      return r;
    endfunction

    function void note_input(input upd_pkg::in_word_t w);
      expected_words.push_back(decode_byte(w));
    endfunction

    function void check_result(input upd_pkg::out_word_t got);
      upd_pkg::out_word_t exp_w;
      if (expected_words.size() == 0) begin
        $error("result word with nothing expected: %h", got);
        mismatches++;
        return;
      end
      exp_w = expected_words.pop_front();
      if (got.out_byte !== exp_w.out_byte) begin
        $error("out_byte: expected %h, got %h", exp_w.out_byte, got.out_byte);
        mismatches++;
      end
      if (got.byte_valid !== exp_w.byte_valid) begin
        $error("byte_valid: expected %b, got %b", exp_w.byte_valid, got.byte_valid);
        mismatches++;
      end
      if (got.done_res !== exp_w.done_res) begin
        $error("done_res: expected %b, got %b", exp_w.done_res, got.done_res);
        mismatches++;
      end
      if (got.status !== exp_w.status) begin
        $error("status: expected %0d, got %0d", exp_w.status, got.status);
        mismatches++;
      end
      if (got.decoded_length !== exp_w.decoded_length) begin
        $error("decoded_length: expected %0d, got %0d",
               exp_w.decoded_length, got.decoded_length);
        mismatches++;
      end
    endfunction

    function int unsigned pending();
      return expected_words.size();
    endfunction
  endclass

  typedef logic [7:0] text_q_t[$];

  logic                     clk_i      = 1'b0;
  logic                     rst_ni     = 1'b0;
  logic                     in_valid_i = 1'b0;
  logic                     in_stall_o;
  upd_pkg::in_word_t        in_data_i  = '0;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  upd_pkg::out_word_t       out_data_o;
  logic                     cfg_we_i   = 1'b0;
  logic [upd_pkg::LenW-1:0] cfg_data_i = '0;

  int unsigned     in_idle_pct     = 37;
  int unsigned     out_stall_pct   = 37;
  int unsigned     hold_off_cycles = 0;
  int unsigned     quiet_cycles    = 0;

  decode_checker   decode_chk = new();

  url_percent_decoder #(
    .MAX_BUFFER(MAX_BUFFER)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  // Sample both channels at the edge where words change hands. The result is
  // checked before the new input is noted: since the result is registered, a
  // result never belongs to the word accepted at the same edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) decode_chk.check_result(out_data_o);
      if (in_valid_i && !in_stall_o) decode_chk.note_input(in_data_i);
      quiet_cycles <= ((out_valid_o && !out_stall_i) || (in_valid_i && !in_stall_o)) ?
                      0 : quiet_cycles + 1;
    end
  end

  // Stop a hung run: nothing has moved on either channel for too long.
  initial begin
    wait (quiet_cycles >= WatchdogLimit);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Result side: stall at random, or hold off for a long stretch on request
  // so the block backs up into its input channel.
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_off_cycles != 0) begin
        out_stall_i <= 1'b1;
        repeat (hold_off_cycles) @(posedge clk_i);
        hold_off_cycles = 0;
      end else begin
        out_stall_i <= ($urandom_range(99) < out_stall_pct);
      end
    end
  end

  // Offer one word, with random idle cycles ahead of it, and hold it until taken.
  task automatic send_word(input upd_pkg::in_word_t w);
    while (in_idle_pct != 0 && $urandom_range(99) < in_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic send_string(input upd_pkg::in_word_t s[$]);
    foreach (s[i]) send_word(s[i]);
  endtask

  // Send a fixed byte sequence as one string; the final byte carries last.
  task automatic send_text(input text_q_t text);
    upd_pkg::in_word_t w;
    foreach (text[i]) begin
      w.in_byte = text[i];
      w.last    = (i == text.size() - 1);
      send_word(w);
    end
  endtask

  // Drop valid and wait until every expected result has arrived, then let
  // the pipeline empty before anything touches the register.
  task automatic settle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (decode_chk.pending() != 0);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_capacity(input logic [upd_pkg::LenW-1:0] v);
    cfg_data_i <= v;
    cfg_we_i   <= 1'b1;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    decode_chk.set_capacity(v);
  endtask

  function automatic logic [7:0] hex_char();
    logic [3:0] v;
    v = 4'($urandom_range(15));
    if (v < 4'd10) return 8'(8'h30 + v);
    return 8'(($urandom_range(1) ? 8'h41 : 8'h61) + v - 8'd10);
  endfunction

  function automatic logic [7:0] non_hex_char();
    logic [7:0] c;
    logic [3:0] d;
    do c = 8'($urandom_range(255)); while (decode_checker::hex_value(c, d));
    return c;
  endfunction

  function automatic void push_byte(ref upd_pkg::in_word_t s[$], input logic [7:0] c);
    upd_pkg::in_word_t w;
    w.in_byte = c;
    w.last    = 1'b0;
    s.push_back(w);
  endfunction

  // Append one token: a plain byte or a full escape, or in a noisy string
  // now and then a broken escape or a raw byte that may be a stray '%'.
  function automatic void add_token(ref upd_pkg::in_word_t s[$], input bit noisy);
    logic [7:0]  c;
    int unsigned roll;
    roll = $urandom_range(99);
    if (noisy && roll < 30) begin
      case ($urandom_range(3))
        0: begin
          push_byte(s, upd_pkg::CharPct);
          push_byte(s, non_hex_char());
        end
        1: begin
          push_byte(s, upd_pkg::CharPct);
          push_byte(s, hex_char());
          push_byte(s, non_hex_char());
        end
        2: push_byte(s, 8'($urandom_range(255)));
        default: push_byte(s, upd_pkg::CharPct);
      endcase
    end else if (roll < 65) begin
      do c = 8'($urandom_range(255)); while (c == upd_pkg::CharPct);
      push_byte(s, c);
    end else begin
      push_byte(s, upd_pkg::CharPct);
      push_byte(s, hex_char());
      push_byte(s, hex_char());
    end
  endfunction

  // Build one string of the given token count; noisy strings may also end
  // inside an escape.
  function automatic void build_string(ref upd_pkg::in_word_t s[$],
                                       input int unsigned tokens, input bit noisy);
    s.delete();
    repeat (tokens) add_token(s, noisy);
    if (noisy && $urandom_range(3) == 0) begin
      push_byte(s, upd_pkg::CharPct);
      if ($urandom_range(1)) push_byte(s, hex_char());
    end
    s[s.size() - 1].last = 1'b1;
  endfunction

  // Random strings until about n_items words went in; request the long
  // receiver hold-off once hold_at words are through (0 skips it).
  task automatic run_strings(input int unsigned n_items, input int unsigned max_tokens,
                             input int unsigned hold_at);
    upd_pkg::in_word_t s[$];
    int unsigned       sent;
    bit                held;
    sent = 0;
    held = 1'b0;
    while (sent < n_items) begin
      build_string(s, $urandom_range(1, max_tokens), $urandom_range(99) < 25);
      if (hold_at != 0 && !held && sent >= hold_at) begin
        hold_off_cycles = HoldOffLen;
        held = 1'b1;
      end
      send_string(s);
      sent += s.size();
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset capacity. Hit the byte extremes, both hex cases, then every way
    // an escape can go wrong: bad first digit, bad second digit with ignored
    // bytes after it, a string ending on '%', and one ending after one digit.
    send_text('{8'h00, 8'hFF, upd_pkg::CharPct, "4", "1", upd_pkg::CharPct, "f", "F",
                upd_pkg::CharPct, "0", "0", "z"});
    send_text('{upd_pkg::CharPct, "G", "x"});
    send_text('{upd_pkg::CharPct, "4", "z", "a"});
    send_text('{upd_pkg::CharPct});
    send_text('{upd_pkg::CharPct, "A"});
    settle();

    // One-byte buffer: the '%' that would start the second token overflows.
    write_capacity(upd_pkg::LenW'(1));
    send_text('{"a", upd_pkg::CharPct, "4", "1"});
    run_strings(60, 4, 0);
    settle();

    // Zero capacity: every string overflows on its first token.
    write_capacity('0);
    send_text('{"b"});
    run_strings(40, 3, 0);
    settle();

    // Tiny buffer with a long receiver hold-off halfway through.
    write_capacity(upd_pkg::LenW'(3));
    run_strings(200, 8, 100);
    settle();

    // Full rate with no idling on either side, with the register above the
    // maximum so it acts as the maximum.
    in_idle_pct   = 0;
    out_stall_pct = 0;
    write_capacity('1);
    run_strings(100, 10, 0);
    settle();

    // Capacity at the maximum, random idling back on.
    in_idle_pct   = 37;
    out_stall_pct = 37;
    write_capacity(upd_pkg::LenW'(MAX_BUFFER));
    run_strings(150, 12, 0);
    settle();

    // Random small capacities, so overflow shows up mid-string.
    repeat (3) begin
      write_capacity(upd_pkg::LenW'($urandom_range(2, 40)));
      run_strings(120, 16, 0);
      settle();
    end

    if (decode_chk.mismatches == 0 && decode_chk.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
